[hw/rtl/sbd_pkg.sv]
// ---------------------------------------------------------------------------
// Shuffle bag draw package
// Field widths, request kinds and response status codes shared by the block.
// ---------------------------------------------------------------------------
package sbd_pkg;

   localparam int KIND_BITS   = 2;
   localparam int VALUE_BITS  = 16;
   localparam int COPIES_BITS = 7;
   localparam int RAND_BITS   = 32;
   localparam int STATUS_BITS = 2;
   localparam int UNDRAWN_BITS = 7;

   localparam logic [KIND_BITS-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_DRAW  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_DRAWN = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd3;

endpackage

[hw/rtl/sbd_if.sv]
// ---------------------------------------------------------------------------
// Shuffle bag channels
// Valid/ready channels for request words and response words.
// ---------------------------------------------------------------------------
interface sbd_req_if import sbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   kind;
   logic [VALUE_BITS-1:0]  item_value;
   logic [COPIES_BITS-1:0] copies;
   logic [RAND_BITS-1:0]   random_value;

   modport source (output valid, kind, item_value, copies, random_value, input ready);
   modport sink   (input valid, kind, item_value, copies, random_value, output ready);
endinterface

interface sbd_rsp_if import sbd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [VALUE_BITS-1:0]   drawn_value;
   logic [STATUS_BITS-1:0]  status;
   logic [UNDRAWN_BITS-1:0] undrawn_count;

   modport source (output valid, drawn_value, status, undrawn_count, input ready);
   modport sink   (input valid, drawn_value, status, undrawn_count, output ready);
endinterface

[hw/rtl/sbd_mem.sv]
// ---------------------------------------------------------------------------
// Shuffle bag entry store
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sbd_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sbd_mul.sv]
// ---------------------------------------------------------------------------
// Shuffle bag position scaler
// Registered (random * span) >> 32 that maps a random word onto a position.
// ---------------------------------------------------------------------------
module sbd_mul import sbd_pkg::*; #(
   parameter int SPAN_BITS = 7
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [RAND_BITS-1:0] rnd,
   input  logic [SPAN_BITS-1:0] span,
   output logic [SPAN_BITS-1:0] pos
);

   localparam int PW = RAND_BITS + SPAN_BITS;

   logic [PW-1:0]        prod;
   logic [SPAN_BITS-1:0] pos_ff;

   assign prod = PW'(rnd) * PW'(span);

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= prod[RAND_BITS +: SPAN_BITS];
      end
   end

   assign pos = pos_ff;

endmodule

[hw/rtl/shuffle_bag_draw.sv]
// ---------------------------------------------------------------------------
// Shuffle bag draw
// Bag of up to DEPTH items drawn at random without replacement.
// ---------------------------------------------------------------------------
// One request word at a time; the next is taken as soon as the previous
// result sits in the response register. An add writes max(copies, 1)
// copies, one per cycle through the single write port (the rest are
// dropped at once when the bag is full); a draw scales the random word,
// then does two reads and two writes of the swap, all through the one
// read and one write port of the entry store; a clear, an empty draw and
// an unused kind go straight from idle to the finish state. Entries are
// kept in reverse order in the store, so pushing onto the front is a
// single write at the fill count. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module shuffle_bag_draw import sbd_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int ITEM_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sbd_req_if.sink   req_chan,
   sbd_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_ADD  = 8'b0000_0010,
      ST_MUL  = 8'b0000_0100,
      ST_RDA  = 8'b0000_1000,
      ST_RDB  = 8'b0001_0000,
      ST_WRA  = 8'b0010_0000,
      ST_WRB  = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           avail_ff, avail_in;
   logic [COPIES_BITS-1:0]  left_ff, left_in;
   logic [VALUE_BITS-1:0]   item_ff, item_in;
   logic [RAND_BITS-1:0]    rnd_ff, rnd_in;
   logic [AW-1:0]           pa_ff, pa_in;
   logic [ITEM_BITS-1:0]    a_ff, a_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_drawn_ff, rsp_drawn_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [UNDRAWN_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                    req_take;
   logic [CW-1:0]           pos;
   logic [CW-1:0]           pa_full;
   logic [CW-1:0]           pt_full;
   logic [CW-1:0]           refill;

   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [ITEM_BITS-1:0]    mem_wr_data;
   logic [AW-1:0]           mem_rd_addr;
   logic [ITEM_BITS-1:0]    mem_rd_data;

   sbd_mem #(
      .DEPTH (DEPTH),
      .WIDTH (ITEM_BITS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sbd_mul #(
      .SPAN_BITS (CW)
   ) u_mul (
      .clock (clock),
      .load  (state_ff == ST_MUL),
      .rnd   (rnd_ff),
      .span  (avail_ff),
      .pos   (pos)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && (state_ff == ST_IDLE);

   assign pa_full = count_ff - CW'(1) - pos;
   assign pt_full = count_ff - avail_ff;
   assign refill  = (avail_ff == '0) ? count_ff : avail_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      avail_in      = avail_ff;
      left_in       = left_ff;
      item_in       = item_ff;
      rnd_in        = rnd_ff;
      pa_in         = pa_ff;
      a_in          = a_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_drawn_in  = rsp_drawn_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[AW-1:0];
      mem_wr_data   = ITEM_BITS'(item_ff);
      mem_rd_addr   = pa_full[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in   = req_chan.item_value;
               rnd_in    = req_chan.random_value;
               left_in   = (req_chan.copies > COPIES_BITS'(1)) ?
                           req_chan.copies : COPIES_BITS'(1);
               a_in      = '0;
               status_in = STATUS_DONE;
               state_in  = ST_FIN;
               case (req_chan.kind)
                  KIND_ADD: begin
                     state_in = ST_ADD;
                  end
                  KIND_DRAW: begin
                     avail_in = refill;
                     if (refill == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     avail_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (count_ff == CW'(DEPTH)) begin
               status_in = STATUS_FULL;
               state_in  = ST_FIN;
            end else begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
               avail_in  = avail_ff + CW'(1);
               left_in   = left_ff - COPIES_BITS'(1);
               if (left_ff == COPIES_BITS'(1)) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_RDA;
         end
         ST_RDA: begin
            pa_in    = pa_full[AW-1:0];
            state_in = ST_RDB;
         end
         ST_RDB: begin
            a_in        = mem_rd_data;
            mem_rd_addr = pt_full[AW-1:0];
            state_in    = ST_WRA;
         end
         ST_WRA: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pa_ff;
            mem_wr_data = mem_rd_data;
            state_in    = ST_WRB;
         end
         ST_WRB: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pt_full[AW-1:0];
            mem_wr_data = a_ff;
            avail_in    = avail_ff - CW'(1);
            status_in   = STATUS_DRAWN;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_drawn_in  = VALUE_BITS'(a_ff);
               rsp_status_in = status_ff;
               rsp_count_in  = UNDRAWN_BITS'(avail_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         avail_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      item_ff       <= item_in;
      rnd_ff        <= rnd_in;
      pa_ff         <= pa_in;
      a_ff          <= a_in;
      status_ff     <= status_in;
      rsp_drawn_ff  <= rsp_drawn_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drawn_value   = rsp_drawn_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.undrawn_count = rsp_count_ff;

   a_avail_in_bag: assert property (@(posedge clock) disable iff (reset)
      avail_ff <= count_ff)
      else $error("undrawn region exceeds bag");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("bag count exceeds depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_ADD || state_ff == ST_WRA || state_ff == ST_WRB))
      else $error("entry write outside add or swap");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("response word loaded outside finish");

endmodule
